### rtl/core/sps_pkg.sv
// ============================================================================
// sps_pkg: shared types and constants of the scan point segmenter
// Field widths, configuration register codes, the item structs of the input,
// output and internal queue, and the scan position codes of the front end.
// ============================================================================
package sps_pkg;

  // fixed field widths
  localparam int CoordW   = 16;
  localparam int GateW    = 16;
  localparam int MinW     = 13;
  localparam int StartW   = 12;
  localparam int LenW     = 13;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam int SqW      = 2 * CoordW;

  // register reset values
  localparam logic [GateW-1:0] GateDistReset = 16'd100;
  localparam logic [MinW-1:0]  MinSizeReset  = 13'd3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GATE_DISTANCE    = 1'b0,
    CFG_MIN_SEGMENT_SIZE = 1'b1
  } cfg_idx_e;

  // position of the next point within its scan
  typedef enum logic [2:0] {
    POS_FIRST  = 3'b001,
    POS_SECOND = 3'b010,
    POS_LATER  = 3'b100
  } scan_pos_e;

  // one scan point
  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     scan_end;
  } point_in_t;

  // one emitted segment
  typedef struct packed {
    logic [StartW-1:0] segment_start;
    logic [LenW-1:0]   segment_length;
    logic              item_last;
  } seg_out_t;

  // classified point passed from front to back
  typedef struct packed {
    logic first;
    logic near;
    logic scan_end;
  } cls_item_t;

endpackage

### rtl/core/sps_front.sv
// ============================================================================
// sps_front: point classification pipeline
// Takes scan points, forms squared distances to the previous point and the
// point two back, and compares them with the squared gate. Pushes one
// classified item per point into the queue; stalls on queue credit.
// ============================================================================
module sps_front #(
  parameter int QCW = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sps_pkg::point_in_t             in_data_i,
  input  logic [sps_pkg::GateW-1:0]      gate_distance_i,
  input  logic [QCW-1:0]                 q_free_i,
  output logic                           push_o,
  output sps_pkg::cls_item_t             push_item_o
);

  localparam int CW = sps_pkg::CoordW;
  localparam int SW = sps_pkg::SqW;

  function automatic logic [CW-1:0] abs_diff(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    logic        [CW:0] m;
    d = {a[CW-1], a} - {b[CW-1], b};
    m = -d;
    return d[CW] ? m[CW-1:0] : d[CW-1:0];
  endfunction

  logic                    accept;
  logic [1:0]              inflight;
  sps_pkg::scan_pos_e      pos_q, pos_d;
  logic signed [CW-1:0]    prev_x_q, prev_y_q, prev2_x_q, prev2_y_q;

  // stage 1: absolute deltas
  logic                    s1_v_q;
  logic [CW-1:0]           adx1_q, ady1_q, adx2_q, ady2_q;
  logic                    s1_first_q, s1_use2_q, s1_last_q;

  // stage 2: squares
  logic                    s2_v_q;
  logic [SW-1:0]           sqx1_q, sqy1_q, sqx2_q, sqy2_q;
  logic                    s2_first_q, s2_use2_q, s2_last_q;

  logic [SW-1:0]           gate_sq_q;
  logic [SW:0]             sum1, sum2;
  logic                    near1, near2;

  // credit check: every item in flight and the new one need a queue slot
  assign inflight   = {1'b0, s1_v_q} + {1'b0, s2_v_q};
  assign in_stall_o = (q_free_i <= QCW'(inflight));
  assign accept     = in_valid_i && !in_stall_o;

  // scan position tracking
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (in_data_i.scan_end) begin
        pos_d = sps_pkg::POS_FIRST;
      end else begin
        case (pos_q)
          sps_pkg::POS_FIRST:  pos_d = sps_pkg::POS_SECOND;
          sps_pkg::POS_SECOND: pos_d = sps_pkg::POS_LATER;
          sps_pkg::POS_LATER:  pos_d = sps_pkg::POS_LATER;
          default:             pos_d = sps_pkg::POS_FIRST;
        endcase
      end
    end
  end

  // control state and point history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= sps_pkg::POS_FIRST;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      prev2_x_q <= '0;
      prev2_y_q <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      if (accept) begin
        prev2_x_q <= prev_x_q;
        prev2_y_q <= prev_y_q;
        prev_x_q  <= in_data_i.point_x;
        prev_y_q  <= in_data_i.point_y;
      end
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    gate_sq_q  <= SW'(gate_distance_i) * SW'(gate_distance_i);
    adx1_q     <= abs_diff(in_data_i.point_x, prev_x_q);
    ady1_q     <= abs_diff(in_data_i.point_y, prev_y_q);
    adx2_q     <= abs_diff(in_data_i.point_x, prev2_x_q);
    ady2_q     <= abs_diff(in_data_i.point_y, prev2_y_q);
    s1_first_q <= (pos_q == sps_pkg::POS_FIRST);
    s1_use2_q  <= (pos_q == sps_pkg::POS_LATER);
    s1_last_q  <= in_data_i.scan_end;
    sqx1_q     <= SW'(adx1_q) * SW'(adx1_q);
    sqy1_q     <= SW'(ady1_q) * SW'(ady1_q);
    sqx2_q     <= SW'(adx2_q) * SW'(adx2_q);
    sqy2_q     <= SW'(ady2_q) * SW'(ady2_q);
    s2_first_q <= s1_first_q;
    s2_use2_q  <= s1_use2_q;
    s2_last_q  <= s1_last_q;
  end

  // gate compare and push
  assign sum1  = {1'b0, sqx1_q} + {1'b0, sqy1_q};
  assign sum2  = {1'b0, sqx2_q} + {1'b0, sqy2_q};
  assign near1 = (sum1 <= {1'b0, gate_sq_q});
  assign near2 = (sum2 <= {1'b0, gate_sq_q});

  assign push_o               = s2_v_q;
  assign push_item_o.first    = s2_first_q;
  assign push_item_o.near     = near1 || (s2_use2_q && near2);
  assign push_item_o.scan_end = s2_last_q;

endmodule

### rtl/core/sps_queue.sv
// ============================================================================
// sps_queue: classified item queue
// Small register queue between the front pipeline and the segment back end.
// Reports its free slot count so the front can run on credits.
// ============================================================================
module sps_queue #(
  parameter int DEPTH = 4,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int QCW  = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sps_pkg::cls_item_t push_item_i,
  input  logic               pop_i,
  output logic               valid_o,
  output sps_pkg::cls_item_t item_o,
  output logic [QCW-1:0]     free_o
);

  sps_pkg::cls_item_t mem_q [DEPTH];
  logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]     count_q;
  logic               do_pop;

  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign free_o  = QCW'(DEPTH) - count_q;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCW'(push_i) - QCW'(do_pop);
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### rtl/core/sps_back.sv
// ============================================================================
// sps_back: run tracking and segment emission
// Pops classified items, keeps the point index and the open run length,
// and emits up to two segments per item through an output register with
// a one-entry hold for the second segment.
// ============================================================================
module sps_back #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  sps_pkg::cls_item_t          q_item_i,
  output logic                        pop_o,
  input  logic [sps_pkg::MinW-1:0]    min_segment_size_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sps_pkg::seg_out_t           out_data_o
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = (CW > sps_pkg::MinW) ? CW : sps_pkg::MinW;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_POINTS);

  logic [CW-1:0]     idx_q, run_q, run_inc, run_mid, count;
  logic [AW-1:0]     min_ext, start1_w, start2_w;
  logic              emit1, emit2, any_emit, out_free, advance;
  sps_pkg::seg_out_t res1, res2;
  sps_pkg::seg_out_t out_q, out_d, hold_q, hold_d;
  logic              out_v_q, out_v_d, hold_v_q, hold_v_d;

  assign min_ext = AW'(min_segment_size_i);
  assign run_inc = (run_q < MaxCnt) ? run_q + 1'b1 : run_q;
  assign count   = (idx_q < MaxCnt) ? idx_q + 1'b1 : MaxCnt;

  // run update and break test
  always_comb begin
    emit1   = 1'b0;
    run_mid = CW'(1);
    if (!q_item_i.first) begin
      if (q_item_i.near) begin
        run_mid = run_inc;
      end else begin
        emit1 = (AW'(run_q) >= min_ext);
      end
    end
  end

  // closing segment at end of scan
  assign emit2    = q_item_i.scan_end && (AW'(run_mid) >= min_ext);
  assign any_emit = emit1 || emit2;
  assign start1_w = AW'(idx_q) - AW'(run_q);
  assign start2_w = (count >= run_mid) ? AW'(count - run_mid) : '0;

  assign res1.segment_start  = start1_w[sps_pkg::StartW-1:0];
  assign res1.segment_length = sps_pkg::LenW'(AW'(run_q));
  assign res1.item_last      = !emit2;
  assign res2.segment_start  = start2_w[sps_pkg::StartW-1:0];
  assign res2.segment_length = sps_pkg::LenW'(AW'(run_mid));
  assign res2.item_last      = 1'b1;

  // handshake with queue and output register
  assign out_free = !out_v_q || !out_stall_i;
  assign advance  = q_valid_i && !hold_v_q && (!any_emit || out_free);
  assign pop_o    = advance;

  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
    if (hold_v_q) begin
      if (out_free) begin
        out_d    = hold_q;
        out_v_d  = 1'b1;
        hold_v_d = 1'b0;
      end
    end else if (advance && any_emit) begin
      out_v_d = 1'b1;
      out_d   = emit1 ? res1 : res2;
      if (emit1 && emit2) begin
        hold_d   = res2;
        hold_v_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      run_q    <= '0;
      out_v_q  <= 1'b0;
      hold_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      hold_v_q <= hold_v_d;
      if (advance) begin
        idx_q <= q_item_i.scan_end ? '0 : count;
        run_q <= q_item_i.scan_end ? '0 : run_mid;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/scan_point_segmenter.sv
// ============================================================================
// scan_point_segmenter: laser scan segmentation by neighbor distance gate
// Splits a stream of scan points into runs of neighboring points and emits
// each run that is long enough as a start index and a length.
// ============================================================================
// Sustained rate is one point per clock while the input is not stalled. An
// accepted point passes through the delta stage, the square stage, the queue
// and the output register in that order, and a segment closed by a point is
// presented from the output register. The output register is the single
// result port: a point that closes two segments holds it for both in turn
// and keeps the back end from popping while the second waits in the hold;
// with the default queue depth this shows up as input stall in a
// back-to-back stream. Input stall rises when the queue credit (free queue
// slots minus points in the front pipeline) runs out. A stalled output blocks
// items that close a segment, so the queue fills and the input stalls. Config
// writes are always taken; write them only while no point is in flight.
module scan_point_segmenter #(
  parameter int MAX_SCAN_POINTS = 4096,
  parameter int QUEUE_DEPTH     = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  sps_pkg::point_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output sps_pkg::seg_out_t                 out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sps_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sps_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic [sps_pkg::GateW-1:0] gate_q;
  logic [sps_pkg::MinW-1:0]  min_q;
  logic                      push, pop, q_valid;
  sps_pkg::cls_item_t        push_item, q_item;
  logic [QCW-1:0]            q_free;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q <= sps_pkg::GateDistReset;
      min_q  <= sps_pkg::MinSizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (sps_pkg::cfg_idx_e'(cfg_index_i))
        sps_pkg::CFG_GATE_DISTANCE:    gate_q <= cfg_data_i[sps_pkg::GateW-1:0];
        sps_pkg::CFG_MIN_SEGMENT_SIZE: min_q  <= cfg_data_i[sps_pkg::MinW-1:0];
        default: ;
      endcase
    end
  end

  // front: distance classification
  sps_front #(
    .QCW (QCW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_data_i       (in_data_i),
    .gate_distance_i (gate_q),
    .q_free_i        (q_free),
    .push_o          (push),
    .push_item_o     (push_item)
  );

  // queue between front and back
  sps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .free_o      (q_free)
  );

  // back: run tracking and segment output
  sps_back #(
    .MAX_POINTS (MAX_SCAN_POINTS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_item_i           (q_item),
    .pop_o              (pop),
    .min_segment_size_i (min_q),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_data_o         (out_data_o)
  );

endmodule

### rtl/core/sps_checker.sv
// ============================================================================
// sps_checker: port-level checks of the scan point segmenter
// Watches the output channel over time: stall behavior, the second segment
// of a pair, and quiet output during and right after reset.
// ============================================================================
module sps_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input sps_pkg::seg_out_t            out_data_o
);

  // a stalled item stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output item changed");

  // the second segment of a pair is a single-point run that follows at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.item_last |=>
      out_valid_o && out_data_o.item_last && (out_data_o.segment_length == 13'd1))
    else $error("second segment of a pair missing or malformed");

  // no output item follows a sampled assertion of reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind scan_point_segmenter sps_checker u_sps_checker (.*);
